/* rtl/core/sws_pkg.sv */
// shared types and codes for the stop-and-wait sender
// no dependencies
`timescale 1ns / 1ps

package sws_pkg;

    localparam int FIELD_W       = 32;
    localparam int RETRY_W       = 8;
    localparam int MODE_W        = 2;
    localparam int ACTION_W      = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int SEQ_WIDTH_DEF = 32;

    localparam logic [FIELD_W-1:0] TIMEOUT_TICKS_RST = 32'd1000;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 8'd10;
    localparam logic [FIELD_W-1:0] COUNT_MAX         = {FIELD_W{1'b1}};

    // event codes
    localparam logic [MODE_W-1:0] MODE_SEGMENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PACKET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    // result codes
    localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TRANSMIT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRANS  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ACKED    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FAILED   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REJECTED = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TOTAL   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] segment_seq;
        logic [FIELD_W-1:0] segment_length;
        logic               rx_ack_flag;
        logic               rx_repeat_flag;
        logic [FIELD_W-1:0] rx_ack_number;
        logic [FIELD_W-1:0] rx_peer_seq;
    } item_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  out_seq;
        logic [FIELD_W-1:0]  acked_peer_seq;
        logic [RETRY_W-1:0]  retries_used;
        logic [FIELD_W-1:0]  timeout_total;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [FIELD_W-1:0]   data;
    } cfg_wr_t;

endpackage

/* rtl/core/sws_in_stage.sv */
// input register stage: holds one event beat ahead of the engine
// depends on sws_pkg
`timescale 1ns / 1ps

module sws_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  sws_pkg::item_t up_item,
    output logic           dn_valid,
    input  logic           dn_ready,
    output sws_pkg::item_t dn_item
);
    import sws_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up_item;
        end
    end

endmodule

/* rtl/core/sws_engine.sv */
// sender state, configuration registers and per-event next-state logic
// depends on sws_pkg
`timescale 1ns / 1ps

module sws_engine #(
    parameter int SEQ_WIDTH = sws_pkg::SEQ_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sws_pkg::cfg_wr_t cfg,
    input  logic             fire,
    input  sws_pkg::item_t   item,
    output sws_pkg::result_t result
);
    import sws_pkg::*;

    logic [FIELD_W-1:0] timeout_ticks_reg;
    logic [RETRY_W-1:0] max_retries_reg;

    logic               busy_reg, busy_next;
    logic [FIELD_W-1:0] pending_seq_reg, pending_seq_next;
    logic [FIELD_W-1:0] pending_length_reg, pending_length_next;
    logic [FIELD_W-1:0] elapsed_reg, elapsed_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [FIELD_W-1:0] total_reg, total_next;

    logic [ACTION_W-1:0]  action;
    logic [FIELD_W-1:0]   peer;
    logic [FIELD_W-1:0]   elapsed_inc;
    logic [SEQ_WIDTH-1:0] expect_ack;
    logic [SEQ_WIDTH-1:0] got_ack;
    logic                 ack_match;

    // ack must equal seq + length modulo the sequence space
    assign expect_ack = SEQ_WIDTH'(pending_seq_reg) + SEQ_WIDTH'(pending_length_reg);
    assign got_ack    = SEQ_WIDTH'(item.rx_ack_number);
    assign ack_match  = (got_ack == expect_ack);

    assign elapsed_inc = (elapsed_reg == COUNT_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        busy_next           = busy_reg;
        pending_seq_next    = pending_seq_reg;
        pending_length_next = pending_length_reg;
        elapsed_next        = elapsed_reg;
        retry_next          = retry_reg;
        total_next          = total_reg;
        action              = ACT_NONE;
        peer                = '0;
        unique case (item.mode)
            MODE_SEGMENT:
            begin
                if (busy_reg)
                begin
                    action = ACT_REJECTED;
                end
                else
                begin
                    pending_seq_next    = item.segment_seq;
                    pending_length_next = item.segment_length;
                    elapsed_next        = '0;
                    retry_next          = '0;
                    busy_next           = 1'b1;
                    action              = ACT_TRANSMIT;
                end
            end
            MODE_PACKET:
            begin
                if (busy_reg && item.rx_ack_flag && !item.rx_repeat_flag && ack_match)
                begin
                    busy_next = 1'b0;
                    peer      = item.rx_peer_seq;
                    action    = ACT_ACKED;
                end
            end
            MODE_TICK:
            begin
                if (busy_reg)
                begin
                    elapsed_next = elapsed_inc;
                    // a zero timeout behaves as one since elapsed_inc is at least one
                    if (elapsed_inc >= timeout_ticks_reg)
                    begin
                        if (retry_reg >= max_retries_reg)
                        begin
                            busy_next = 1'b0;
                            action    = ACT_FAILED;
                        end
                        else
                        begin
                            retry_next   = retry_reg + 1'b1;
                            total_next   = (total_reg == COUNT_MAX) ? total_reg
                                                                    : total_reg + 1'b1;
                            elapsed_next = '0;
                            action       = ACT_RETRANS;
                        end
                    end
                end
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

    assign result.action         = action;
    assign result.out_seq        = pending_seq_next;
    assign result.acked_peer_seq = peer;
    assign result.retries_used   = retry_next;
    assign result.timeout_total  = total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            max_retries_reg   <= MAX_RETRIES_RST;
        end
        else if (cfg.we)
        begin
            if (cfg.index == REG_TIMEOUT_TICKS)
            begin
                timeout_ticks_reg <= cfg.data;
            end
            if (cfg.index == REG_MAX_RETRIES)
            begin
                max_retries_reg <= cfg.data[RETRY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg           <= 1'b0;
            pending_seq_reg    <= '0;
            pending_length_reg <= '0;
            elapsed_reg        <= '0;
            retry_reg          <= '0;
            total_reg          <= '0;
        end
        else
        begin
            if (fire)
            begin
                busy_reg           <= busy_next;
                pending_seq_reg    <= pending_seq_next;
                pending_length_reg <= pending_length_next;
                elapsed_reg        <= elapsed_next;
                retry_reg          <= retry_next;
                total_reg          <= total_next;
            end
            // the user must send the clear strobe only while idle; the block itself does not enforce it
            if (cfg.we && cfg.index == REG_CLEAR_TOTAL && cfg.data[0])
            begin
                total_reg <= '0;
            end
        end
    end

endmodule

/* rtl/core/sws_out_stage.sv */
// result register stage: holds one result beat until it is taken
// depends on sws_pkg
`timescale 1ns / 1ps

module sws_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  sws_pkg::result_t up_result,
    output logic             dn_valid,
    input  logic             dn_ready,
    output sws_pkg::result_t dn_result
);
    import sws_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign up_ready  = !valid_reg || dn_ready;
    assign dn_valid  = valid_reg;
    assign dn_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            result_reg <= up_result;
        end
    end

endmodule

/* rtl/core/stop_and_wait_sender.sv */
// top level of the stop-and-wait sender: input register, engine, result register
// depends on sws_pkg, sws_in_stage, sws_engine, sws_out_stage
//
//  channel  | signals                                  | beat taken when
//  ---------+------------------------------------------+--------------------------
//  in       | in_valid/in_ready + event fields         | in_valid & in_ready
//  out      | out_valid/out_ready + result fields      | out_valid & out_ready
//  cfg      | cfg_we, cfg_index, cfg_data              | cfg_we
//
// one event per cycle sustained while out_ready stays high; an event is held in the input
// register, and its result is captured in the result register for its out beat.
// reset clears sender state and both stage valids, and loads register defaults.
// a stalled out side fills the result register, then the input register, then
// drops in_ready; nothing is lost or repeated.
`timescale 1ns / 1ps

module stop_and_wait_sender #(
    parameter int SEQ_WIDTH = sws_pkg::SEQ_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] segment_seq,
    input  logic [31:0] segment_length,
    input  logic        rx_ack_flag,
    input  logic        rx_repeat_flag,
    input  logic [31:0] rx_ack_number,
    input  logic [31:0] rx_peer_seq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [31:0] out_seq,
    output logic [31:0] acked_peer_seq,
    output logic [7:0]  retries_used,
    output logic [31:0] timeout_total,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sws_pkg::*;

    item_t   in_item;
    item_t   eng_item;
    logic    eng_valid;
    logic    eng_ready;
    result_t eng_result;
    result_t out_result;
    cfg_wr_t cfg;

    assign in_item.mode           = mode;
    assign in_item.segment_seq    = segment_seq;
    assign in_item.segment_length = segment_length;
    assign in_item.rx_ack_flag    = rx_ack_flag;
    assign in_item.rx_repeat_flag = rx_repeat_flag;
    assign in_item.rx_ack_number  = rx_ack_number;
    assign in_item.rx_peer_seq    = rx_peer_seq;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    sws_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_item  (in_item),
        .dn_valid (eng_valid),
        .dn_ready (eng_ready),
        .dn_item  (eng_item)
    );

    sws_engine #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (eng_valid && eng_ready),
        .item   (eng_item),
        .result (eng_result)
    );

    sws_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (eng_valid),
        .up_ready  (eng_ready),
        .up_result (eng_result),
        .dn_valid  (out_valid),
        .dn_ready  (out_ready),
        .dn_result (out_result)
    );

    assign action         = out_result.action;
    assign out_seq        = out_result.out_seq;
    assign acked_peer_seq = out_result.acked_peer_seq;
    assign retries_used   = out_result.retries_used;
    assign timeout_total  = out_result.timeout_total;

endmodule
